// ===== design/address_netmask_access_list_assert.svh =====
// assertion macros used by the access list top level
`ifndef ADDRESS_NETMASK_ACCESS_LIST_ASSERT_SVH
`define ADDRESS_NETMASK_ACCESS_LIST_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define ANACL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ANACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/anacl_pkg.sv =====
// types and constants of the address/netmask access list
package anacl_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 16;
   localparam int MODE_W                = 2;
   localparam int FAMILY_W              = 2;
   localparam int ADDR_W                = 64;
   localparam int ENTRY_COUNT_W         = 5;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

   localparam logic [FAMILY_W-1:0] FAMILY_V4 = 2'd0;
   localparam logic [FAMILY_W-1:0] FAMILY_V6 = 2'd1;

   // ::ffff:a.b.c.d marker in bits 47..32 of the low half
   localparam logic [15:0] V4MAPPED_TAG = 16'hFFFF;

   typedef struct packed {
      logic              is_ipv6;
      logic [ADDR_W-1:0] address_high;
      logic [ADDR_W-1:0] address_low;
      logic [ADDR_W-1:0] mask_high;
      logic [ADDR_W-1:0] mask_low;
   } entry_type;

   typedef struct packed {
      logic [FAMILY_W-1:0] family;
      logic [ADDR_W-1:0]   address_high;
      logic [ADDR_W-1:0]   address_low;
   } client_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== design/anacl_req_if.sv =====
// request channel: one clear, add or check beat
interface anacl_req_if import anacl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [FAMILY_W-1:0] family;
   logic [ADDR_W-1:0]   address_high;
   logic [ADDR_W-1:0]   address_low;
   logic [ADDR_W-1:0]   netmask_high;
   logic [ADDR_W-1:0]   netmask_low;

   modport source (
      output valid, mode, family, address_high, address_low, netmask_high, netmask_low,
      input  ready
   );
   modport sink (
      input  valid, mode, family, address_high, address_low, netmask_high, netmask_low,
      output ready
   );
endinterface

// ===== design/anacl_rsp_if.sv =====
// response channel: one result beat per request
interface anacl_rsp_if import anacl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     permit;
   logic                     add_rejected;
   logic [ENTRY_COUNT_W-1:0] entry_count;

   modport source (
      output valid, permit, add_rejected, entry_count,
      input  ready
   );
   modport sink (
      input  valid, permit, add_rejected, entry_count,
      output ready
   );
endinterface

// ===== design/anacl_ram.sv =====
// generic single write port ram with registered read
module anacl_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/anacl_match.sv =====
// compares one stored entry against the client address under the entry mask
module anacl_match import anacl_pkg::*; (
   input  entry_type  entry,
   input  client_type client,
   output logic       hit
);

   logic mapped;
   logic v4_hit;
   logic v6_hit;

   // ipv4-mapped ipv6 client: upper half zero, ffff tag above the v4 address
   assign mapped = (client.address_high == '0) &&
                   (client.address_low[ADDR_W-1:48] == '0) &&
                   (client.address_low[47:32] == V4MAPPED_TAG);

   // masked compares
   assign v4_hit = ((client.address_low[31:0] & entry.mask_low[31:0]) ==
                    (entry.address_low[31:0] & entry.mask_low[31:0]));
   assign v6_hit = ((client.address_high & entry.mask_high) ==
                    (entry.address_high & entry.mask_high)) &&
                   ((client.address_low & entry.mask_low) ==
                    (entry.address_low & entry.mask_low));

   // family rules
   always_comb begin
      case (client.family)
         FAMILY_V4: hit = !entry.is_ipv6 && v4_hit;
         FAMILY_V6: hit = entry.is_ipv6 ? v6_hit : (mapped && v4_hit);
         default:   hit = 1'b0;
      endcase
   end

endmodule

// ===== design/address_netmask_access_list.sv =====
// top level: access list controller, entry ram and scan compare
// clear, add, unused mode and checks needing no scan: the done state loads the result
// into the output register; check with a scan: one ram read per cycle from entry 0,
// ending early on a hit, then the done state; the next beat is taken once the
// result is in the output register, which holds it while the sink stalls
// reset empties the list at once through the fill count; the ram is not swept
`include "address_netmask_access_list_assert.svh"

module address_netmask_access_list import anacl_pkg::*; #(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   anacl_req_if.sink          req_chan,
   anacl_rsp_if.source        rsp_chan
);

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = $bits(entry_type);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   client_type               client_ff, client_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     issue_done_ff, issue_done_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic                     rd_last_ff, rd_last_in;
   logic                     res_permit_ff, res_permit_in;
   logic                     res_rejected_ff, res_rejected_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_permit_ff, rsp_permit_in;
   logic                     rsp_rejected_ff, rsp_rejected_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                     req_ready;
   logic                     req_accept;
   logic                     rsp_free;
   logic                     family_ok;
   logic                     table_full;
   logic                     table_empty;
   logic                     add_ok;
   logic                     last_issue;
   logic                     scan_hit;
   logic                     scan_end;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   entry_type                wr_entry;
   entry_type                rd_entry;
   logic [ENTRY_W-1:0]       ram_rd_data;

   // handshake and list status
   assign req_accept  = req_chan.valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign family_ok   = (req_chan.family == FAMILY_V4) || (req_chan.family == FAMILY_V6);
   assign table_full  = (count_ff == CNT_W'(TABLE_ENTRIES));
   assign table_empty = (count_ff == '0);
   assign add_ok      = !table_full && family_ok;
   assign last_issue  = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);
   assign scan_end    = rd_pend_ff && (scan_hit || rd_last_ff);

   // entry as stored: ipv4 keeps the low 32 bits of address and mask only
   always_comb begin
      wr_entry.is_ipv6 = (req_chan.family == FAMILY_V6);
      if (req_chan.family == FAMILY_V6) begin
         wr_entry.address_high = req_chan.address_high;
         wr_entry.address_low  = req_chan.address_low;
         wr_entry.mask_high    = req_chan.netmask_high;
         wr_entry.mask_low     = req_chan.netmask_low;
      end else begin
         wr_entry.address_high = '0;
         wr_entry.address_low  = {{(ADDR_W-32){1'b0}}, req_chan.address_low[31:0]};
         wr_entry.mask_high    = '0;
         wr_entry.mask_low     = {{(ADDR_W-32){1'b0}}, req_chan.netmask_low[31:0]};
      end
   end

   // entry store; a write happens only on an add beat and reads only while
   // scanning a later check, so read and write of one entry never overlap
   anacl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = ram_rd_data;

   // compare of the entry read last cycle
   anacl_match u_match (
      .entry  (rd_entry),
      .client (client_ff),
      .hit    (scan_hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.mode == MODE_CHECK && !table_empty && family_ok) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_wr_en = req_chan.valid && (req_chan.mode == MODE_ADD) && add_ok;
         end
         ST_SCAN: ram_rd_en = !issue_done_ff;
         ST_DONE: ;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      count_in        = count_ff;
      client_in       = client_ff;
      rd_idx_in       = rd_idx_ff;
      issue_done_in   = issue_done_ff;
      rd_pend_in      = 1'b0;
      rd_last_in      = rd_last_ff;
      res_permit_in   = res_permit_ff;
      res_rejected_in = res_rejected_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_permit_in   = rsp_permit_ff;
      rsp_rejected_in = rsp_rejected_ff;
      rsp_count_in    = rsp_count_ff;

      // decode of an accepted beat
      if (req_accept) begin
         res_permit_in   = 1'b0;
         res_rejected_in = 1'b0;
         case (req_chan.mode)
            MODE_CLEAR: count_in = '0;
            MODE_ADD: begin
               if (add_ok) begin
                  count_in = count_ff + CNT_W'(1);
               end
               res_rejected_in = !add_ok;
            end
            MODE_CHECK: begin
               client_in.family       = req_chan.family;
               client_in.address_high = req_chan.address_high;
               client_in.address_low  = req_chan.address_low;
               res_permit_in          = table_empty;
               rd_idx_in              = '0;
               issue_done_in          = 1'b0;
            end
            default: ;
         endcase
      end

      // scan: issue one read a cycle, judge the entry that comes back
      if (state_ff == ST_SCAN) begin
         if (ram_rd_en) begin
            rd_idx_in     = rd_idx_ff + IDX_W'(1);
            issue_done_in = last_issue;
            rd_last_in    = last_issue;
         end
         rd_pend_in = ram_rd_en && !scan_end;
         if (scan_end) begin
            res_permit_in = scan_hit;
         end
      end

      // load the output register
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in    = 1'b1;
         rsp_permit_in   = res_permit_ff;
         rsp_rejected_in = res_rejected_ff;
         rsp_count_in    = ENTRY_COUNT_W'(count_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issue_done_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_done_ff <= issue_done_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      client_ff       <= client_in;
      rd_idx_ff       <= rd_idx_in;
      rd_last_ff      <= rd_last_in;
      res_permit_ff   <= res_permit_in;
      res_rejected_ff <= res_rejected_in;
      rsp_permit_ff   <= rsp_permit_in;
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_count_ff    <= rsp_count_in;
   end

   // ports
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.permit       = rsp_permit_ff;
   assign rsp_chan.add_rejected = rsp_rejected_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

   // checks
   `ANACL_ASSERT_SAME(a_write_has_room, clock, reset, ram_wr_en, count_ff < CNT_W'(TABLE_ENTRIES), "add wrote past the list end")
   `ANACL_ASSERT_NEXT(a_clear_empties, clock, reset, req_accept && req_chan.mode == MODE_CLEAR, count_ff == '0, "clear left entries")
   `ANACL_ASSERT_SAME(a_scan_needs_entries, clock, reset, state_ff == ST_SCAN, count_ff != '0, "scan of an empty list")
   `ANACL_ASSERT_NEXT(a_empty_check_permits, clock, reset, req_accept && req_chan.mode == MODE_CHECK && count_ff == '0, state_ff == ST_DONE && res_permit_ff, "empty list check not permitted")

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the address/netmask access list
`timescale 1ns / 1ps

module testbench;
   import anacl_pkg::*;

   localparam int LIST_DEPTH = DEFAULT_TABLE_ENTRIES;
   localparam int ITEMS_PER_PHASE = 550;
   localparam int SETTLE_CYCLES = 40;

   localparam logic [MODE_W-1:0]   MODE_UNUSED     = 2'd3;
   localparam logic [FAMILY_W-1:0] FAMILY_OTHER    = 2'd2;
   localparam logic [FAMILY_W-1:0] FAMILY_RESERVED = 2'd3;
   localparam logic [ADDR_W-1:0]   ALL_ONES        = '1;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [FAMILY_W-1:0] family;
      logic [ADDR_W-1:0]   address_high;
      logic [ADDR_W-1:0]   address_low;
      logic [ADDR_W-1:0]   netmask_high;
      logic [ADDR_W-1:0]   netmask_low;
   } acl_request_type;

   typedef struct packed {
      logic                     permit;
      logic                     add_rejected;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } acl_verdict_type;

   typedef struct packed {
      logic [4:0]      copies;
      acl_request_type item;
      logic            typed;
      acl_verdict_type verdict;
   } directed_row_type;

   localparam acl_verdict_type NOT_TYPED = '0;

   // directed rows: typed verdicts only where they are obvious
   directed_row_type directed_rows [18] = '{
      '{5'd1, '{MODE_CHECK, FAMILY_V4, 64'h0, 64'h0A01_0203, 64'h0, 64'h0},
        1'b1, '{1'b1, 1'b0, 5'd0}},
      '{5'd1, '{MODE_CHECK, FAMILY_OTHER, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES},
        1'b1, '{1'b1, 1'b0, 5'd0}},
      '{5'd1, '{MODE_UNUSED, FAMILY_V6, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES},
        1'b1, '{1'b0, 1'b0, 5'd0}},
      '{5'd1, '{MODE_ADD, FAMILY_OTHER, 64'h0, 64'h0A01_0000, 64'h0, 64'hFFFF_0000},
        1'b1, '{1'b0, 1'b1, 5'd0}},
      '{5'd1, '{MODE_ADD, FAMILY_RESERVED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES},
        1'b1, '{1'b0, 1'b1, 5'd0}},
      '{5'd1, '{MODE_ADD, FAMILY_V4, ALL_ONES, 64'hFFFF_FFFF_0A01_0000, ALL_ONES,
                64'h1234_5678_FFFF_0000}, 1'b1, '{1'b0, 1'b0, 5'd1}},
      '{5'd1, '{MODE_CHECK, FAMILY_V4, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_0A01_0203,
                64'h0, 64'h0}, 1'b0, NOT_TYPED},
      '{5'd1, '{MODE_CHECK, FAMILY_V4, 64'h0, 64'h0A02_0001, 64'h0, 64'h0}, 1'b0, NOT_TYPED},
      '{5'd1, '{MODE_CHECK, FAMILY_V6, 64'h0, 64'h0000_FFFF_0A01_0505, 64'h0, 64'h0},
        1'b0, NOT_TYPED},
      '{5'd1, '{MODE_CHECK, FAMILY_V6, 64'h0, 64'h0000_FFFE_0A01_0505, 64'h0, 64'h0},
        1'b0, NOT_TYPED},
      '{5'd1, '{MODE_CHECK, FAMILY_OTHER, 64'h0, 64'h0000_FFFF_0A01_0505, 64'h0, 64'h0},
        1'b0, NOT_TYPED},
      '{5'd1, '{MODE_ADD, FAMILY_V6, 64'h2001_0DB8_0000_0000, 64'h0,
                64'hFFFF_FFFF_0000_0000, 64'h0}, 1'b0, NOT_TYPED},
      '{5'd1, '{MODE_CHECK, FAMILY_V6, 64'h2001_0DB8_ABCD_0001, 64'h1234_5678_9ABC_DEF0,
                64'h0, 64'h0}, 1'b0, NOT_TYPED},
      '{5'd1, '{MODE_CHECK, FAMILY_V4, 64'h0, 64'h2001_0DB8, 64'h0, 64'h0}, 1'b0, NOT_TYPED},
      '{5'd14, '{MODE_ADD, FAMILY_V6, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES},
        1'b0, NOT_TYPED},
      '{5'd1, '{MODE_ADD, FAMILY_V4, 64'h0, 64'h0A00_0000, 64'h0, 64'hFF00_0000},
        1'b1, '{1'b0, 1'b1, 5'd16}},
      '{5'd1, '{MODE_CHECK, FAMILY_V6, ALL_ONES, ALL_ONES, 64'h0, 64'h0}, 1'b0, NOT_TYPED},
      '{5'd1, '{MODE_CLEAR, FAMILY_V4, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES},
        1'b1, '{1'b0, 1'b0, 5'd0}}
   };

   logic clock = 1'b0;
   logic reset;

   anacl_req_if req_bus ();
   anacl_rsp_if rsp_bus ();

   address_netmask_access_list u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predicted list contents
   bit           acl_live [LIST_DEPTH];
   entry_type    acl_entry [LIST_DEPTH];
   int unsigned  acl_fill;

   acl_verdict_type pending_verdicts [$];
   int              error_count;
   int              send_idle_pct = 7;
   int              recv_idle_pct = 55;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit v4_hit(entry_type e, logic [31:0] client);
      return (client & e.mask_low[31:0]) == (e.address_low[31:0] & e.mask_low[31:0]);
   endfunction

   function automatic bit v6_hit(entry_type e, logic [63:0] hi, logic [63:0] lo);
      return ((hi & e.mask_high) == (e.address_high & e.mask_high)) &&
             ((lo & e.mask_low) == (e.address_low & e.mask_low));
   endfunction

   // update the predicted list with one accepted beat and return its verdict
   function automatic acl_verdict_type apply_to_list(acl_request_type r);
      acl_verdict_type v;
      entry_type       e;
      bit              any;
      bit              hit;
      bit              mapped;
      int              i;
      v = '0;
      case (r.mode)
         MODE_CLEAR: begin
            for (i = 0; i < LIST_DEPTH; i++) acl_live[i] = 1'b0;
            acl_fill = 0;
         end
         MODE_ADD: begin
            if (acl_fill >= LIST_DEPTH || (r.family != FAMILY_V4 && r.family != FAMILY_V6)) begin
               v.add_rejected = 1'b1;
            end else begin
               e = '0;
               e.is_ipv6 = (r.family == FAMILY_V6);
               if (e.is_ipv6) begin
                  e.address_high = r.address_high;
                  e.address_low  = r.address_low;
                  e.mask_high    = r.netmask_high;
                  e.mask_low     = r.netmask_low;
               end else begin
                  e.address_low[31:0] = r.address_low[31:0];
                  e.mask_low[31:0]    = r.netmask_low[31:0];
               end
               acl_entry[acl_fill] = e;
               acl_live[acl_fill]  = 1'b1;
               acl_fill++;
            end
         end
         MODE_CHECK: begin
            any    = 1'b0;
            hit    = 1'b0;
            mapped = (r.address_high == '0) && (r.address_low[63:48] == '0) &&
                     (r.address_low[47:32] == V4MAPPED_TAG);
            for (i = 0; i < LIST_DEPTH; i++) begin
               if (acl_live[i]) begin
                  any = 1'b1;
                  e = acl_entry[i];
                  if (r.family == FAMILY_V4) begin
                     if (!e.is_ipv6 && v4_hit(e, r.address_low[31:0])) hit = 1'b1;
                  end else if (r.family == FAMILY_V6) begin
                     if (!e.is_ipv6) begin
                        if (mapped && v4_hit(e, r.address_low[31:0])) hit = 1'b1;
                     end else if (v6_hit(e, r.address_high, r.address_low)) begin
                        hit = 1'b1;
                     end
                  end
               end
            end
            v.permit = hit || !any;
         end
         default: ;
      endcase
      v.entry_count = acl_fill[ENTRY_COUNT_W-1:0];
      return v;
   endfunction

   // random beat: mostly adds and checks aimed at stored entries, some noise
   function automatic acl_request_type make_random_item();
      acl_request_type r;
      entry_type       e;
      int              roll;
      logic [127:0]    m;
      logic [127:0]    a;
      logic [31:0]     m4;
      logic [31:0]     c4;
      logic [95:0]     top;
      r.mode         = MODE_CHECK;
      r.family       = FAMILY_V4;
      r.address_high = rand64();
      r.address_low  = rand64();
      r.netmask_high = rand64();
      r.netmask_low  = rand64();
      roll = $urandom_range(99);
      if (roll < 2) begin
         r.mode = MODE_CLEAR;
      end else if (roll < 4) begin
         r.mode   = MODE_UNUSED;
         r.family = FAMILY_W'($urandom_range(3));
      end else if (roll < 36) begin
         r.mode = MODE_ADD;
         roll = $urandom_range(99);
         if (roll < 45) r.family = FAMILY_V4;
         else if (roll < 92) r.family = FAMILY_V6;
         else r.family = $urandom_range(1) ? FAMILY_OTHER : FAMILY_RESERVED;
         // prefix masks most of the time, raw random masks otherwise
         if ($urandom_range(3) != 0) begin
            if (r.family == FAMILY_V4) begin
               m4 = '1;
               m4 = m4 << (32 - $urandom_range(32));
               r.netmask_low[31:0] = m4;
            end else begin
               m = '1;
               m = m << (128 - $urandom_range(128));
               {r.netmask_high, r.netmask_low} = m;
            end
         end
      end else if (acl_fill != 0 && $urandom_range(3) != 0) begin
         // client built from a stored entry, sometimes with one bit flipped
         e = acl_entry[$urandom_range(acl_fill - 1)];
         if (e.is_ipv6) begin
            r.family = FAMILY_V6;
            m = {e.mask_high, e.mask_low};
            a = ({e.address_high, e.address_low} & m) | ({rand64(), rand64()} & ~m);
            if ($urandom_range(2) == 0) a = a ^ (128'h1 << $urandom_range(127));
            {r.address_high, r.address_low} = a;
         end else begin
            c4 = (e.address_low[31:0] & e.mask_low[31:0]) | ($urandom & ~e.mask_low[31:0]);
            if ($urandom_range(2) == 0) c4 = c4 ^ (32'h1 << $urandom_range(31));
            if ($urandom_range(1)) begin
               r.family = FAMILY_V4;
               r.address_low[31:0] = c4;
            end else begin
               r.family       = FAMILY_V6;
               r.address_high = '0;
               r.address_low  = {16'h0000, V4MAPPED_TAG, c4};
               // broken mapped prefix
               if ($urandom_range(5) == 0) begin
                  top = {r.address_high, r.address_low[63:32]} ^ (96'h1 << $urandom_range(95));
                  {r.address_high, r.address_low[63:32]} = top;
               end
            end
         end
      end else begin
         r.family = ($urandom_range(9) == 0) ? FAMILY_W'($urandom_range(3))
                                             : FAMILY_W'($urandom_range(1));
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // drive one beat at the falling edge and hold it until taken
   task automatic send_request(input acl_request_type item, input bit typed,
                               input acl_verdict_type typed_verdict);
      acl_verdict_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= item.mode;
      req_bus.family       <= item.family;
      req_bus.address_high <= item.address_high;
      req_bus.address_low  <= item.address_low;
      req_bus.netmask_high <= item.netmask_high;
      req_bus.netmask_low  <= item.netmask_low;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_to_list(item);
      pending_verdicts.push_back(typed ? typed_verdict : predicted);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_verdicts.size() != 0);
   endtask

   // result sink stalls
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each result beat with the oldest pending verdict
   always @(posedge clock) begin
      acl_verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending (count %0d)",
                                      rsp_bus.entry_count));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_bus.permit !== want.permit)
               report_mismatch($sformatf("permit got %b want %b",
                                         rsp_bus.permit, want.permit));
            if (rsp_bus.add_rejected !== want.add_rejected)
               report_mismatch($sformatf("add_rejected got %b want %b",
                                         rsp_bus.add_rejected, want.add_rejected));
            if (rsp_bus.entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d want %0d",
                                         rsp_bus.entry_count, want.entry_count));
         end
      end
   end

   initial begin
      int row;
      int copy;
      int phase;
      int n;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_CLEAR;
      req_bus.family       = FAMILY_V4;
      req_bus.address_high = '0;
      req_bus.address_low  = '0;
      req_bus.netmask_high = '0;
      req_bus.netmask_low  = '0;
      rsp_bus.ready        = 1'b0;
      error_count          = 0;
      acl_fill             = 0;
      foreach (acl_live[i]) acl_live[i] = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (row = 0; row < $size(directed_rows); row++) begin
         for (copy = 0; copy < directed_rows[row].copies; copy++) begin
            send_request(directed_rows[row].item, directed_rows[row].typed,
                         directed_rows[row].verdict);
         end
      end

      // random phases: sender idles little, then receiver idles little, then no idling
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 7;  recv_idle_pct = 55; end
            1: begin send_idle_pct = 55; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         hold_until_drained();
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) == 0) hold_until_drained();
            send_request(make_random_item(), 1'b0, NOT_TYPED);
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #12_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
